@@ src/okct_pkg.sv @@
// ---------------------------------------------------------------------------
// okct_pkg
// shared types and codes for the ordered keyed counter table
// ---------------------------------------------------------------------------
package okct_pkg;

    localparam int OP_W          = 3;
    localparam int ITEM_TYPE_W   = 8;
    localparam int AMOUNT_W      = 16;
    localparam int POSITION_W    = 4;
    localparam int STATUS_W      = 3;
    localparam int ENTRY_COUNT_W = 5;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_REMOVE    = 3'd1,
        OP_POP_FRONT = 3'd2,
        OP_POP_BACK  = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED    = 3'd0,
        ST_NEW      = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_REDUCED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5,
        ST_BADPOS   = 3'd6,
        ST_READ     = 3'd7
    } status_t;

    typedef struct packed {
        logic [OP_W-1:0]        operation;
        logic [ITEM_TYPE_W-1:0] item_type;
        logic [AMOUNT_W-1:0]    amount;
        logic [POSITION_W-1:0]  position;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [ITEM_TYPE_W-1:0]   result_type;
        logic [AMOUNT_W-1:0]      result_quantity;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } rsp_t;

    // command broadcast to every cell
    typedef struct packed {
        logic by_key;
        logic add;
        logic sub;
        logic drop;
        logic append;
    } cell_ctl_t;

    // per-cell status back to the controller
    typedef struct packed {
        logic hit;
        logic covers;
    } cell_flags_t;

endpackage

@@ src/okct_chan_if.sv @@
// ---------------------------------------------------------------------------
// okct_chan_if
// valid/ready channel carrying one word of a given payload type
// ---------------------------------------------------------------------------
interface okct_chan_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );

endinterface

@@ src/ordered_keyed_counter_table.sv @@
// ---------------------------------------------------------------------------
// ordered_keyed_counter_table
// insertion-ordered table of (type, count) pairs held in a row of cells
// ---------------------------------------------------------------------------
//   port   dir  word                                             handshake
//   req    in   operation, item_type, amount, position           valid/ready
//   rsp    out  status, result_type, result_quantity, entry_count valid/ready
//
// a request passes through S_IDLE, which captures the word, then S_EXEC, in which
// all cells compare key or index in parallel and update or shift toward the front.
// reset clears the entry count, state and result word; slot contents are not cleared.
// a new word is taken only while idle and the result register is empty or
// draining in the same cycle, so rsp stalls hold off req.
// ---------------------------------------------------------------------------
module ordered_keyed_counter_table #(
    parameter int CAPACITY   = 16,
    parameter int TYPE_BITS  = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    okct_chan_if.sink   req,
    okct_chan_if.source rsp
);
    import okct_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (OCC_W > POSITION_W) ? OCC_W : POSITION_W;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    req_t             req_reg;

    logic                  accept;
    logic                  exec;
    op_t                   op;
    logic [TYPE_BITS-1:0]  key;
    logic [COUNT_BITS-1:0] amt;
    logic [IDX_W-1:0]      target;
    logic                  full;
    logic                  pos_ok;
    cell_ctl_t             ctl;

    logic [TYPE_BITS-1:0]  nb_type  [0:CAPACITY];
    logic [COUNT_BITS-1:0] nb_count [0:CAPACITY];
    logic                  sh       [0:CAPACITY];
    cell_flags_t           flags    [0:CAPACITY-1];
    logic [TYPE_BITS-1:0]  res_type [0:CAPACITY-1];
    logic [COUNT_BITS-1:0] res_count[0:CAPACITY-1];
    logic [CAPACITY-1:0]   hit_vec;

    logic                  any_hit;
    logic                  any_cover;
    logic [TYPE_BITS-1:0]  sel_type;
    logic [COUNT_BITS-1:0] sel_count;

    assign accept    = req.valid && req.ready;
    assign exec      = (state_reg == S_EXEC);
    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = rsp_reg;

    assign op     = op_t'(req_reg.operation);
    assign key    = TYPE_BITS'(req_reg.item_type);
    assign amt    = COUNT_BITS'(req_reg.amount);
    assign full   = (occ_reg == OCC_W'(CAPACITY));
    assign pos_ok = CMP_W'(req_reg.position) < CMP_W'(occ_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req.payload;
        end
    end

    // command to the cells, only during the execute cycle
    always_comb
    begin
        ctl    = '0;
        target = '0;
        if (exec)
        begin
            unique case (op)
                OP_INSERT:
                begin
                    ctl.by_key = 1'b1;
                    ctl.add    = 1'b1;
                    ctl.append = !full;
                end
                OP_REMOVE:
                begin
                    ctl.by_key = 1'b1;
                    ctl.sub    = 1'b1;
                end
                OP_POP_FRONT:
                begin
                    ctl.drop = 1'b1;
                end
                OP_POP_BACK:
                begin
                    target = IDX_W'(occ_reg - OCC_W'(1));
                end
                OP_READ:
                begin
                    target = IDX_W'(req_reg.position);
                end
                default:
                begin
                    ctl = '0;
                end
            endcase
        end
    end

    assign nb_type[CAPACITY]  = '0;
    assign nb_count[CAPACITY] = '0;
    assign sh[0]              = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        okct_cell #(
            .INDEX      (g),
            .TYPE_BITS  (TYPE_BITS),
            .COUNT_BITS (COUNT_BITS),
            .IDX_W      (IDX_W),
            .OCC_W      (OCC_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .key        (key),
            .amt        (amt),
            .target     (target),
            .occ        (occ_reg),
            .found      (any_hit),
            .shift_in   (sh[g]),
            .next_type  (nb_type[g+1]),
            .next_count (nb_count[g+1]),
            .shift_out  (sh[g+1]),
            .cell_type  (nb_type[g]),
            .cell_count (nb_count[g]),
            .flags      (flags[g]),
            .res_type   (res_type[g]),
            .res_count  (res_count[g])
        );
        assign hit_vec[g] = flags[g].hit;
    end

    // at most one cell hits, so an OR picks its values
    always_comb
    begin
        any_hit   = 1'b0;
        any_cover = 1'b0;
        sel_type  = '0;
        sel_count = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            any_hit   = any_hit | flags[i].hit;
            any_cover = any_cover | (flags[i].hit & flags[i].covers);
            sel_type  = sel_type | res_type[i];
            sel_count = sel_count | res_count[i];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        occ_next       = occ_reg;
        rsp_next       = rsp_reg;
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next                = S_IDLE;
                out_valid_next            = 1'b1;
                rsp_next.status           = ST_NOTFOUND;
                rsp_next.result_type      = '0;
                rsp_next.result_quantity  = '0;
                unique case (op)
                    OP_INSERT:
                    begin
                        rsp_next.result_type = ITEM_TYPE_W'(key);
                        if (any_hit)
                        begin
                            rsp_next.status          = ST_ADDED;
                            rsp_next.result_quantity = AMOUNT_W'(sel_count);
                        end
                        else if (full)
                        begin
                            rsp_next.status = ST_FULL;
                        end
                        else
                        begin
                            rsp_next.status          = ST_NEW;
                            rsp_next.result_quantity = AMOUNT_W'(amt);
                            occ_next                 = occ_reg + OCC_W'(1);
                        end
                    end
                    OP_REMOVE:
                    begin
                        rsp_next.result_type = ITEM_TYPE_W'(key);
                        if (any_hit)
                        begin
                            rsp_next.result_quantity = AMOUNT_W'(sel_count);
                            if (any_cover)
                            begin
                                rsp_next.status = ST_REMOVED;
                                occ_next        = occ_reg - OCC_W'(1);
                            end
                            else
                            begin
                                rsp_next.status = ST_REDUCED;
                            end
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK:
                    begin
                        if (occ_reg != '0)
                        begin
                            rsp_next.status          = ST_REMOVED;
                            rsp_next.result_type     = ITEM_TYPE_W'(sel_type);
                            rsp_next.result_quantity = AMOUNT_W'(sel_count);
                            occ_next                 = occ_reg - OCC_W'(1);
                        end
                    end
                    OP_READ:
                    begin
                        if (pos_ok)
                        begin
                            rsp_next.status          = ST_READ;
                            rsp_next.result_type     = ITEM_TYPE_W'(sel_type);
                            rsp_next.result_quantity = AMOUNT_W'(sel_count);
                        end
                        else
                        begin
                            rsp_next.status = ST_BADPOS;
                        end
                    end
                    default:
                    begin
                        rsp_next.status = ST_NOTFOUND;
                    end
                endcase
                rsp_next.entry_count = ENTRY_COUNT_W'(occ_next);
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            occ_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            occ_reg       <= occ_next;
            rsp_reg       <= rsp_next;
        end
    end

`ifndef SYNTHESIS
    // types are unique among live entries, so at most one cell matches
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        exec |-> $onehot0(hit_vec))
        else $error("more than one cell hit");

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("entry count above capacity");

    a_occ_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(occ_reg))
        else $error("entry count moved outside execute");

    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EXEC))
        else $error("result word without execute cycle");

    a_pop_shift: assert property (@(posedge clk) disable iff (!rst_n)
        (exec && (op == OP_POP_FRONT) && (occ_reg != '0)) |-> sh[CAPACITY])
        else $error("pop front did not shift the whole row");
`endif

endmodule

@@ src/okct_cell.sv @@
// ---------------------------------------------------------------------------
// okct_cell
// one table slot: compare, saturating add, subtract and shift from neighbor
// ---------------------------------------------------------------------------
module okct_cell #(
    parameter int INDEX      = 0,
    parameter int TYPE_BITS  = 8,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4,
    parameter int OCC_W      = 5
) (
    input  logic                    clk,
    input  okct_pkg::cell_ctl_t     ctl,
    input  logic [TYPE_BITS-1:0]    key,
    input  logic [COUNT_BITS-1:0]   amt,
    input  logic [IDX_W-1:0]        target,
    input  logic [OCC_W-1:0]        occ,
    input  logic                    found,
    input  logic                    shift_in,
    input  logic [TYPE_BITS-1:0]    next_type,
    input  logic [COUNT_BITS-1:0]   next_count,
    output logic                    shift_out,
    output logic [TYPE_BITS-1:0]    cell_type,
    output logic [COUNT_BITS-1:0]   cell_count,
    output okct_pkg::cell_flags_t   flags,
    output logic [TYPE_BITS-1:0]    res_type,
    output logic [COUNT_BITS-1:0]   res_count
);
    import okct_pkg::*;

    logic [TYPE_BITS-1:0]  type_reg;
    logic [COUNT_BITS-1:0] count_reg;
    logic [TYPE_BITS-1:0]  type_next;
    logic [COUNT_BITS-1:0] count_next;

    logic                  valid;
    logic                  hit;
    logic                  covers;
    logic                  del;
    logic                  take;
    logic                  append_here;
    logic [COUNT_BITS:0]   sum_full;
    logic [COUNT_BITS-1:0] sum_sat;
    logic [COUNT_BITS-1:0] diff;
    logic [COUNT_BITS-1:0] upd_count;

    assign valid       = OCC_W'(INDEX) < occ;
    assign hit         = valid && (ctl.by_key ? (type_reg == key) : (target == IDX_W'(INDEX)));
    assign covers      = (amt == '0) || (amt >= count_reg);
    assign sum_full    = {1'b0, count_reg} + {1'b0, amt};
    assign sum_sat     = sum_full[COUNT_BITS] ? '1 : sum_full[COUNT_BITS-1:0];
    assign diff        = count_reg - amt;
    assign del         = ctl.drop || (ctl.sub && covers);
    // everything at or after the deleted slot pulls its right neighbor in
    assign take        = shift_in || (hit && del);
    // a new key lands in the first free slot when no live slot matched
    assign append_here = ctl.append && !found && (occ == OCC_W'(INDEX));

    always_comb
    begin
        if (ctl.add)
        begin
            upd_count = sum_sat;
        end
        else if (ctl.sub && !covers)
        begin
            upd_count = diff;
        end
        else
        begin
            upd_count = count_reg;
        end
    end

    always_comb
    begin
        type_next  = type_reg;
        count_next = count_reg;
        if (append_here)
        begin
            type_next  = key;
            count_next = amt;
        end
        else if (take)
        begin
            type_next  = next_type;
            count_next = next_count;
        end
        else if (hit && (ctl.add || ctl.sub))
        begin
            count_next = upd_count;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        count_reg <= count_next;
    end

    assign shift_out    = take;
    assign cell_type    = type_reg;
    assign cell_count   = count_reg;
    assign flags.hit    = hit;
    assign flags.covers = covers;
    assign res_type     = hit ? type_reg : '0;
    assign res_count    = hit ? upd_count : '0;

endmodule

@@ tb/okct_table_checker.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// okct_table_checker
// watches the req and rsp channels of the ordered keyed counter table, keeps
// its own copy of the table, predicts one result per accepted request and
// compares every field of each returned word with the oldest prediction
// ---------------------------------------------------------------------------
module okct_table_checker #(
    parameter int CAPACITY = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    input  logic            req_ready,
    input  okct_pkg::req_t  req_word,
    input  logic            rsp_valid,
    input  logic            rsp_ready,
    input  okct_pkg::rsp_t  rsp_word,
    output int              mismatches,
    output int              outstanding,
    output int              results_seen,
    output logic [7:0]      statuses_seen
);
    import okct_pkg::*;

    logic [ITEM_TYPE_W-1:0] slot_type [CAPACITY];
    logic [AMOUNT_W-1:0]    slot_count[CAPACITY];
    int                     fill;
    rsp_t                   pending_results[$];

    // close the gap left by the entry at idx
    function automatic void close_gap(input int idx);
        for (int i = idx; i + 1 < fill; i++)
        begin
            slot_type[i]  = slot_type[i + 1];
            slot_count[i] = slot_count[i + 1];
        end
        fill--;
    endfunction

    function automatic rsp_t apply_request(input req_t w);
        rsp_t              r;
        int                hit;
        logic [AMOUNT_W:0] sum;
        r.status          = ST_NOTFOUND;
        r.result_type     = '0;
        r.result_quantity = '0;
        hit = -1;
        for (int i = 0; i < fill; i++)
        begin
            if (hit < 0 && slot_type[i] == w.item_type)
                hit = i;
        end
        case (w.operation)
            OP_INSERT:
            begin
                r.result_type = w.item_type;
                if (hit >= 0)
                begin
                    sum = {1'b0, slot_count[hit]} + {1'b0, w.amount};
                    slot_count[hit]   = sum[AMOUNT_W] ? '1 : sum[AMOUNT_W-1:0];
                    r.status          = ST_ADDED;
                    r.result_quantity = slot_count[hit];
                end
                else if (fill >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slot_type[fill]   = w.item_type;
                    slot_count[fill]  = w.amount;
                    fill++;
                    r.status          = ST_NEW;
                    r.result_quantity = w.amount;
                end
            end
            OP_REMOVE:
            begin
                r.result_type = w.item_type;
                if (hit < 0)
                begin
                    r.status = ST_NOTFOUND;
                end
                else if (w.amount == '0 || w.amount >= slot_count[hit])
                begin
                    r.status          = ST_REMOVED;
                    r.result_quantity = slot_count[hit];
                    close_gap(hit);
                end
                else
                begin
                    slot_count[hit]   = slot_count[hit] - w.amount;
                    r.status          = ST_REDUCED;
                    r.result_quantity = slot_count[hit];
                end
            end
            OP_POP_FRONT:
            begin
                if (fill > 0)
                begin
                    r.status          = ST_REMOVED;
                    r.result_type     = slot_type[0];
                    r.result_quantity = slot_count[0];
                    close_gap(0);
                end
            end
            OP_POP_BACK:
            begin
                if (fill > 0)
                begin
                    r.status          = ST_REMOVED;
                    r.result_type     = slot_type[fill - 1];
                    r.result_quantity = slot_count[fill - 1];
                    fill--;
                end
            end
            OP_READ:
            begin
                if (int'(w.position) < fill)
                begin
                    r.status          = ST_READ;
                    r.result_type     = slot_type[w.position];
                    r.result_quantity = slot_count[w.position];
                end
                else
                begin
                    r.status = ST_BADPOS;
                end
            end
            default:
            begin
                // unused operation codes leave the table alone
            end
        endcase
        r.entry_count = ENTRY_COUNT_W'(fill);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            fill = 0;
            pending_results.delete();
            mismatches    = 0;
            outstanding   = 0;
            results_seen  = 0;
            statuses_seen = '0;
        end
        else
        begin
            if (req_valid && req_ready)
                pending_results.push_back(apply_request(req_word));
            if (rsp_valid && rsp_ready)
            begin
                results_seen++;
                statuses_seen[rsp_word.status] = 1'b1;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: %p", $time, rsp_word);
                    mismatches++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp_word.status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, rsp_word.status);
                        mismatches++;
                    end
                    if (rsp_word.result_type !== want.result_type)
                    begin
                        $display("%0t: result_type expected %h actual %h",
                                 $time, want.result_type, rsp_word.result_type);
                        mismatches++;
                    end
                    if (rsp_word.result_quantity !== want.result_quantity)
                    begin
                        $display("%0t: result_quantity expected %h actual %h",
                                 $time, want.result_quantity, rsp_word.result_quantity);
                        mismatches++;
                    end
                    if (rsp_word.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, rsp_word.entry_count);
                        mismatches++;
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

@@ tb/ordered_keyed_counter_table_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ordered_keyed_counter_table_test
// drives request words into the table under random idling and one long
// result stall, and reports the verdict from the checker's mismatch count
// ---------------------------------------------------------------------------
module ordered_keyed_counter_table_test;
    import okct_pkg::*;

    localparam int CAPACITY     = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 280;
    localparam int HOLD_START   = 400;
    localparam int HOLD_CYCLES  = 70;
    localparam int DRAIN_CYCLES = 10;
    localparam int CYCLE_LIMIT  = 60000;

    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef enum int {
        BURST_MIXED,
        BURST_FILL,
        BURST_DRAIN,
        BURST_SWEEP
    } burst_t;

    logic       clk;
    logic       rst_n;
    logic       calm;
    int         cycle_count = 0;
    int         words_sent;
    int         mismatches;
    int         outstanding;
    int         results_seen;
    logic [7:0] statuses_seen;

    okct_chan_if #(.payload_t(req_t)) req_ch ();
    okct_chan_if #(.payload_t(rsp_t)) rsp_ch ();

    ordered_keyed_counter_table #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    okct_table_checker #(
        .CAPACITY (CAPACITY)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_ch.valid),
        .req_ready     (req_ch.ready),
        .req_word      (req_ch.payload),
        .rsp_valid     (rsp_ch.valid),
        .rsp_ready     (rsp_ch.ready),
        .rsp_word      (rsp_ch.payload),
        .mismatches    (mismatches),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .statuses_seen (statuses_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outstanding);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic req_t word_of(input logic [OP_W-1:0] op,
                                     input logic [ITEM_TYPE_W-1:0] key,
                                     input logic [AMOUNT_W-1:0] amt,
                                     input logic [POSITION_W-1:0] pos);
        req_t w;
        w.operation = op;
        w.item_type = key;
        w.amount    = amt;
        w.position  = pos;
        return w;
    endfunction

    function automatic logic [AMOUNT_W-1:0] pick_amount();
        logic [AMOUNT_W-1:0] amt;
        case ($urandom_range(0, 9))
            0:       amt = '0;
            1:       amt = '1;
            2:       amt = AMOUNT_W'($urandom());
            3:       amt = 16'hFFF0 + AMOUNT_W'($urandom_range(0, 15));
            default: amt = AMOUNT_W'($urandom_range(1, 60));
        endcase
        return amt;
    endfunction

    // mostly a small key pool so that adds and removes find their entries
    function automatic logic [ITEM_TYPE_W-1:0] pick_key();
        if ($urandom_range(0, 4) == 0)
            return ITEM_TYPE_W'($urandom());
        return ITEM_TYPE_W'($urandom_range(0, 23));
    endfunction

    function automatic req_t make_word(input burst_t kind, input int step);
        req_t w;
        int   roll;
        w = word_of(OP_INSERT, pick_key(), pick_amount(),
                    POSITION_W'($urandom_range(0, 15)));
        roll = $urandom_range(0, 99);
        case (kind)
            BURST_FILL:
            begin
                // fresh keys push the table toward full
                w.item_type = ITEM_TYPE_W'($urandom());
                if (roll < 10)
                    w.operation = OP_READ;
            end
            BURST_DRAIN:
            begin
                if (roll < 50)
                    w.operation = OP_REMOVE;
                else if (roll < 75)
                    w.operation = OP_POP_FRONT;
                else
                    w.operation = OP_POP_BACK;
            end
            BURST_SWEEP:
            begin
                w.operation = OP_READ;
                w.position  = POSITION_W'(step);
            end
            default:
            begin
                if (roll < 35)
                    w.operation = OP_INSERT;
                else if (roll < 60)
                    w.operation = OP_REMOVE;
                else if (roll < 80)
                    w.operation = OP_READ;
                else if (roll < 88)
                    w.operation = OP_POP_FRONT;
                else if (roll < 96)
                    w.operation = OP_POP_BACK;
                else
                    w.operation = OP_UNUSED_FIRST
                                  + OP_W'($urandom_range(0, OP_UNUSED_LAST - OP_UNUSED_FIRST));
            end
        endcase
        return w;
    endfunction

    task automatic send_word(input req_t w);
        while (!calm && $urandom_range(0, 99) < 14)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= w;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    // result side: random stalls plus one long hold-off to back up the table
    initial
    begin
        int rx_cycles;
        rx_cycles    = 0;
        rsp_ch.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            if (rx_cycles == HOLD_START)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= calm || $urandom_range(0, 99) >= 14;
            end
        end
    end

    initial
    begin
        req_t   directed[$];
        burst_t kind;
        int     roll;
        int     random_sent;
        int     settle;
        rst_n          = 1'b0;
        calm           = 1'b0;
        words_sent     = 0;
        random_sent    = 0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;

        // empty table, unused codes, saturation and the remove variants
        directed.push_back(word_of(OP_POP_FRONT, 8'h00, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_POP_BACK, 8'h00, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_READ, 8'h00, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_REMOVE, 8'hFF, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_UNUSED_FIRST, 8'hFF, 16'hFFFF, 4'hF));
        directed.push_back(word_of(OP_UNUSED_LAST, 8'h00, 16'h0001, 4'h0));
        directed.push_back(word_of(OP_INSERT, 8'hFF, 16'hFFFF, 4'h0));
        directed.push_back(word_of(OP_INSERT, 8'hFF, 16'h0001, 4'h0));
        directed.push_back(word_of(OP_INSERT, 8'h00, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_READ, 8'h00, 16'h0000, 4'h1));
        directed.push_back(word_of(OP_READ, 8'h00, 16'h0000, 4'hF));
        directed.push_back(word_of(OP_INSERT, 8'h5A, 16'd100, 4'h0));
        directed.push_back(word_of(OP_INSERT, 8'hA5, 16'd200, 4'h0));
        directed.push_back(word_of(OP_REMOVE, 8'h00, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_READ, 8'h00, 16'h0000, 4'h1));
        directed.push_back(word_of(OP_REMOVE, 8'hFF, 16'h0001, 4'h0));
        directed.push_back(word_of(OP_REMOVE, 8'h5A, 16'd100, 4'h0));
        directed.push_back(word_of(OP_REMOVE, 8'hA5, 16'd201, 4'h0));
        directed.push_back(word_of(OP_INSERT, 8'h03, 16'd7, 4'h0));
        directed.push_back(word_of(OP_POP_BACK, 8'h00, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_POP_FRONT, 8'h00, 16'h0000, 4'h0));
        directed.push_back(word_of(OP_POP_FRONT, 8'h00, 16'h0000, 4'h0));

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_word(directed[i]);

        while (random_sent < RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
                kind = BURST_MIXED;
            else if (roll < 6)
                kind = BURST_FILL;
            else if (roll < 8)
                kind = BURST_DRAIN;
            else
                kind = BURST_SWEEP;
            for (int step = 0; step < 16 && random_sent < RANDOM_ITEMS; step++)
            begin
                calm = random_sent >= CALM_FIRST && random_sent < CALM_LAST;
                send_word(make_word(kind, step));
                random_sent++;
            end
        end
        calm = 1'b0;
        req_ch.valid <= 1'b0;
        // let the checker record the last accepted word
        @(posedge clk);

        while (outstanding != 0)
            @(posedge clk);
        settle = 0;
        while (settle < DRAIN_CYCLES)
        begin
            @(posedge clk);
            settle++;
        end

        $display("sent %0d request words (%0d directed), checked %0d result words",
                 words_sent, directed.size(), results_seen);
        $display("status codes returned (bit per code): %b", statuses_seen);
        if (mismatches == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/okct_pkg.sv
src/okct_chan_if.sv
src/okct_cell.sv
src/ordered_keyed_counter_table.sv
tb/okct_table_checker.sv
tb/ordered_keyed_counter_table_test.sv
